[hdl/des_round_key_schedule_core_defines.svh]
// Assertion helpers for the DES round key schedule core.
`ifndef DES_ROUND_KEY_SCHEDULE_CORE_DEFINES_SVH
`define DES_ROUND_KEY_SCHEDULE_CORE_DEFINES_SVH

// Checked on every edge outside reset.
`define RKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define RKS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/des_rks_pkg.sv]
package des_rks_pkg;

  localparam int RKS_MAX_ROUNDS = 16;
  localparam int KEY_W          = 64;
  localparam int CD_W           = 56;
  localparam int HALF_W         = 28;
  localparam int SUBKEY_W       = 48;
  localparam int ROUND_W        = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER = 1'b1;

  localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 5'd16;

  localparam logic [7:0] PC1 [CD_W] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
    8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
  };

  localparam logic [7:0] PC2 [SUBKEY_W] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
  };

  // one stored subkey with the round it belongs to
  typedef struct packed {
    logic [SUBKEY_W-1:0] key;
    logic [ROUND_W-1:0]  round;
  } rks_slot_t;

  function automatic logic [CD_W-1:0] pc1_sel(input logic [KEY_W-1:0] k);
    logic [CD_W-1:0] cd;
    for (int i = 0; i < CD_W; i++) begin
      cd[CD_W-1-i] = k[KEY_W - int'(PC1[i])];
    end
    return cd;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2_sel(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] k;
    for (int j = 0; j < SUBKEY_W; j++) begin
      k[SUBKEY_W-1-j] = cd[CD_W - int'(PC2[j])];
    end
    return k;
  endfunction

  // total left rotation of each half after rounds 1..r
  function automatic int cum_shift(input int r);
    int s;
    s = 0;
    for (int i = 0; i < r; i++) begin
      s += (i == 0 || i == 1 || i == 8 || i == 15) ? 1 : 2;
    end
    return s;
  endfunction

  function automatic logic [HALF_W-1:0] rotl_half(input logic [HALF_W-1:0] h, input int amt);
    logic [2*HALF_W-1:0] dbl;
    dbl = {h, h} << amt;
    return dbl[2*HALF_W-1:HALF_W];
  endfunction

endpackage

[hdl/des_rks_if.sv]
// key channel
interface des_rks_key_if
  import des_rks_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] cipher_key;

  modport source (output valid, output cipher_key, input ready);
  modport sink   (input valid, input cipher_key, output ready);
endinterface

// subkey channel
interface des_rks_sub_if
  import des_rks_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SUBKEY_W-1:0] subkey;
  logic [ROUND_W-1:0]  round_number;
  logic                last_key;

  modport source (output valid, output subkey, output round_number, output last_key,
                  input ready);
  modport sink   (input valid, input subkey, input round_number, input last_key,
                  output ready);
endinterface

[hdl/des_rks_cell.sv]
// One slot of the subkey row. Loads its own round's subkey from C||D,
// then passes it one place per transfer toward the output end.
module des_rks_cell
  import des_rks_pkg::*;
#(
  parameter int ROUND = 1
) (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  logic            rev_i,
  input  logic [CD_W-1:0] cd_i,
  input  rks_slot_t       lo_i,
  input  rks_slot_t       hi_i,
  output rks_slot_t       slot_o
);

  localparam int ROT = cum_shift(ROUND);

  rks_slot_t       slot_q, slot_d;
  logic [CD_W-1:0] cd_rot;

  assign cd_rot = {rotl_half(cd_i[CD_W-1:HALF_W], ROT), rotl_half(cd_i[HALF_W-1:0], ROT)};

  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d.key   = pc2_sel(cd_rot);
      slot_d.round = ROUND_W'(ROUND);
    end else if (shift_i) begin
      slot_d = rev_i ? lo_i : hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

[hdl/des_round_key_schedule_core.sv]
// DES round key schedule. Each key transferred in yields n subkeys, where n
// is round_count (0 or anything above MAX_ROUNDS counts as MAX_ROUNDS), one
// per cycle while the subkey channel is ready, with the round number and a
// last marker. All n subkeys are formed at once when the key is taken, into
// a row of MAX_ROUNDS cells, and then leave the row one per subkey transfer.
// The next key is taken in the cycle the current one's last subkey transfers,
// so a steady stream runs with no gap. With reverse_order set the subkeys
// come out from round n down to round 1. Configuration is to be written by
// the user only while no subkeys are pending; the block does not enforce it.
module des_round_key_schedule_core
  import des_rks_pkg::*;
#(
  parameter int MAX_ROUNDS = RKS_MAX_ROUNDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  des_rks_key_if.sink           key_in,
  des_rks_sub_if.source         sub_out,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

`include "des_round_key_schedule_core_defines.svh"

  localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
  localparam int IDX_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  // configuration registers
  logic [ROUND_W-1:0] round_count_q;
  logic               reverse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= ROUND_COUNT_RESET;
      reverse_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROUND_COUNT:   round_count_q <= cfg_wdata_i[ROUND_W-1:0];
        CFG_REVERSE_ORDER: reverse_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // effective run length; zero or over-range means a full run
  logic [ROUND_W-1:0] eff_round;
  logic [CNT_W-1:0]   eff_n;
  logic [CNT_W-1:0]   last_pos;
  logic [IDX_W-1:0]   last_idx;

  assign eff_round = (round_count_q == '0 || round_count_q > ROUND_W'(MAX_ROUNDS)) ?
                     ROUND_W'(MAX_ROUNDS) : round_count_q;
  assign eff_n     = eff_round[CNT_W-1:0];
  assign last_pos  = eff_n - CNT_W'(1);
  assign last_idx  = last_pos[IDX_W-1:0];

  // pending subkeys of the current key
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_xfer, out_xfer;

  assign out_xfer     = sub_out.valid && sub_out.ready;
  assign key_in.ready = (cnt_q == '0) || (cnt_q == CNT_W'(1) && sub_out.ready);
  assign in_xfer      = key_in.valid && key_in.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer) begin
      cnt_d = eff_n;
    end else if (out_xfer) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // cell row: cell i holds round i+1 after a load. Forward runs drain
  // toward cell 0; reverse runs drain toward the top and read cell n-1.
  logic [CD_W-1:0] cd_key;
  rks_slot_t       slots [MAX_ROUNDS];
  logic            shift;

  assign cd_key = pc1_sel(key_in.cipher_key);
  assign shift  = out_xfer && !in_xfer;

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_cell
    rks_slot_t lo, hi;
    if (i == 0) begin : g_lo_end
      assign lo = '0;
    end else begin : g_lo
      assign lo = slots[i-1];
    end
    if (i == MAX_ROUNDS - 1) begin : g_hi_end
      assign hi = '0;
    end else begin : g_hi
      assign hi = slots[i+1];
    end

    des_rks_cell #(
      .ROUND (i + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .load_i  (in_xfer),
      .shift_i (shift),
      .rev_i   (reverse_q),
      .cd_i    (cd_key),
      .lo_i    (lo),
      .hi_i    (hi),
      .slot_o  (slots[i])
    );
  end

  rks_slot_t head;
  assign head = reverse_q ? slots[last_idx] : slots[0];

  assign sub_out.valid        = (cnt_q != '0);
  assign sub_out.subkey       = head.key;
  assign sub_out.round_number = head.round;
  assign sub_out.last_key     = (cnt_q == CNT_W'(1));

  `RKS_ASSERT(a_load_count, in_xfer |=> cnt_q == $past(eff_n), "run length not loaded")
  `RKS_ASSERT(a_no_early_key, (cnt_q > CNT_W'(1)) |-> !key_in.ready, "key taken mid-run")
  `RKS_ASSERT(a_count_down, out_xfer && !sub_out.last_key |=> cnt_q == $past(cnt_q) - 1'b1,
              "pending count did not step")
  `RKS_ASSERT(a_fwd_order, out_xfer && !sub_out.last_key && !reverse_q |=>
              sub_out.round_number == $past(sub_out.round_number) + 1'b1,
              "forward rounds out of order")

endmodule
